// ----- rtl/core/atr_pkg.sv -----
// Shared constants, types and helper functions of the average true range block.
`timescale 1ns / 1ps

package atr_pkg;

	localparam int PERIOD_MAX   = 64;
	localparam int PRICE_BITS   = 32;
	localparam int PERIOD_REG_W = 7;
	localparam int FIELD_W      = 32;

	localparam logic [PERIOD_REG_W-1:0] PERIOD_RESET = PERIOD_REG_W'(14);

	// divisor width, bar counter width (holds PERIOD_MAX + 1), range sum width;
	// the smoothed ATR can reach the sum width after a period change, so the
	// dividend needs room for it times N-1
	localparam int NW     = $clog2(PERIOD_MAX + 1);
	localparam int CNT_W  = $clog2(PERIOD_MAX + 2);
	localparam int SUM_W  = PRICE_BITS + $clog2(PERIOD_MAX);
	localparam int DIV_W  = SUM_W + $clog2(PERIOD_MAX);
	localparam int PROD_W = SUM_W + NW;
	localparam int STEP_W = $clog2(DIV_W + 1);

	typedef logic [PERIOD_REG_W-1:0] period_reg_t;
	typedef logic [NW-1:0]           period_t;
	typedef logic [CNT_W-1:0]        count_t;
	typedef logic [PRICE_BITS-1:0]   price_t;
	typedef logic [SUM_W-1:0]        sum_t;
	typedef logic [DIV_W-1:0]        dividend_t;
	typedef logic [FIELD_W-1:0]      field_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANGE,
		S_MUL,
		S_DIV,
		S_OUT
	} state_t;

	// period 0 acts as 1, anything above PERIOD_MAX acts as PERIOD_MAX
	function automatic period_t eff_period(input period_reg_t p);
		period_t r;
		if (p == '0) begin
			r = NW'(1);
		end else if (int'(p) > PERIOD_MAX) begin
			r = NW'(PERIOD_MAX);
		end else begin
			r = NW'(p);
		end
		return r;
	endfunction

	function automatic price_t to_price(input field_t v);
		logic [PRICE_BITS+FIELD_W-1:0] w;
		w = {{PRICE_BITS{1'b0}}, v};
		return w[PRICE_BITS-1:0];
	endfunction

	function automatic field_t to_field(input sum_t v);
		logic [SUM_W+FIELD_W-1:0] w;
		w = {{FIELD_W{1'b0}}, v};
		return w[FIELD_W-1:0];
	endfunction

endpackage

// ----- rtl/core/atr_if.sv -----
// Request channel interfaces: price bars in, ATR results out.
`timescale 1ns / 1ps

interface bar_if;
	logic        valid;
	logic        ready;
	logic [31:0] bar_high;
	logic [31:0] bar_low;
	logic [31:0] bar_close;

	modport source (output valid, bar_high, bar_low, bar_close, input ready);
	modport sink   (input valid, bar_high, bar_low, bar_close, output ready);
endinterface

interface atr_if;
	logic        valid;
	logic        ready;
	logic [31:0] atr_value;
	logic        atr_valid;

	modport source (output valid, atr_value, atr_valid, input ready);
	modport sink   (input valid, atr_value, atr_valid, output ready);
endinterface

// ----- rtl/core/atr_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module atr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  atr_pkg::dividend_t dividend,
	input  atr_pkg::period_t   divisor,
	output logic               done,
	output atr_pkg::dividend_t quotient
);
	import atr_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	dividend_t         quo_q;
	period_t           rem_q;
	period_t           dvs_q;

	logic [NW:0] trial;
	logic [NW:0] diff;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[NW]) begin
				rem_q <= diff[NW-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[NW-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/average_true_range.sv -----
// Top level: Wilder average true range over a stream of price bars.
`timescale 1ns / 1ps

// One request is one price bar (high, low, close, unsigned Q16.16); each bar
// gives exactly one result. The first bar only stores its close; the next
// N-1 bars add their true range and give an invalid (zero) result; bar N+1 gives
// the plain average of the N true ranges, and every later bar the Wilder
// smoothing (prev_atr*(N-1)+TR)/N, truncated. N is the period register, taken at
// the next bar after a write; 0 acts as 1 and values above 64 act as 64.
// Warm-up bars skip the divider; the bar that gives the first average and
// every smoothing bar (after a multiply step) go through the shared
// 44-step bit-serial divider. A new bar is taken while the previous result
// still sits in the output register; it waits in its last step until that
// result is accepted.

module average_true_range (
	input  logic                 clk,
	input  logic                 arst_n,
	bar_if.sink                  bar,
	atr_if.source                atr,
	input  logic                 cfg_we,
	input  atr_pkg::period_reg_t cfg_wdata
);
	import atr_pkg::*;

	state_t      state_q, state_d;
	period_reg_t period_q;

	price_t      hi_q, lo_q, cl_q;
	period_t     n_q;
	count_t      bar_cnt_q;
	price_t      last_close_q;
	sum_t        range_sum_q;
	sum_t        smoothed_q;
	price_t      tr_q;
	logic        rv_q;

	logic        res_valid_q;
	field_t      res_value_q;
	logic        res_atr_valid_q;

	price_t      top, bottom, tr;
	sum_t        sum_next;
	logic [PROD_W-1:0] prod;
	dividend_t   mul_dividend;
	logic        is_first, is_fill, is_avg;

	logic        accept;
	logic        div_start;
	logic        div_done;
	dividend_t   div_dividend;
	dividend_t   div_quotient;
	logic        out_load;

	assign accept = bar.valid && bar.ready;

	// true range and warm-up classification
	always_comb begin
		top      = (hi_q > last_close_q) ? hi_q : last_close_q;
		bottom   = (lo_q < last_close_q) ? lo_q : last_close_q;
		tr       = top - bottom;
		sum_next = range_sum_q + SUM_W'(tr);
		is_first = (bar_cnt_q == '0);
		is_fill  = !is_first && (bar_cnt_q < CNT_W'(n_q));
		is_avg   = (bar_cnt_q == CNT_W'(n_q));
		prod     = PROD_W'(smoothed_q) * PROD_W'(n_q - NW'(1));
		mul_dividend = DIV_W'(prod + PROD_W'(tr_q));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_RANGE;
			end
			S_RANGE: begin
				priority if (is_first || is_fill) state_d = S_OUT;
				else if (is_avg)                   state_d = S_DIV;
				else                               state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		bar.ready    = 1'b0;
		div_start    = 1'b0;
		div_dividend = DIV_W'(sum_next);
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				bar.ready = 1'b1;
			end
			S_RANGE: begin
				div_start = is_avg;
			end
			S_MUL: begin
				div_start    = 1'b1;
				div_dividend = mul_dividend;
			end
			S_DIV: begin
			end
			S_OUT: begin
				out_load = !res_valid_q || atr.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			period_q     <= PERIOD_RESET;
			bar_cnt_q    <= '0;
			last_close_q <= '0;
			range_sum_q  <= '0;
			smoothed_q   <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) period_q <= cfg_wdata;

			if (state_q == S_RANGE) begin
				last_close_q <= cl_q;
				priority if (is_first) begin
					bar_cnt_q <= CNT_W'(1);
				end else if (is_fill) begin
					range_sum_q <= sum_next;
					bar_cnt_q   <= bar_cnt_q + CNT_W'(1);
				end else if (is_avg) begin
					range_sum_q <= sum_next;
					bar_cnt_q   <= CNT_W'(n_q) + CNT_W'(1);
				end else begin
					bar_cnt_q   <= CNT_W'(n_q) + CNT_W'(1);
				end
			end

			if (div_done) smoothed_q <= div_quotient[SUM_W-1:0];

			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (atr.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hi_q <= to_price(bar.bar_high);
			lo_q <= to_price(bar.bar_low);
			cl_q <= to_price(bar.bar_close);
			n_q  <= eff_period(period_q);
		end
		if (state_q == S_RANGE) begin
			tr_q <= tr;
			rv_q <= !(is_first || is_fill);
		end
		if (out_load) begin
			res_atr_valid_q <= rv_q;
			res_value_q     <= rv_q ? to_field(smoothed_q) : '0;
		end
	end

	atr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign atr.valid     = res_valid_q;
	assign atr.atr_value = res_value_q;
	assign atr.atr_valid = res_atr_valid_q;

	a_accept_to_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_RANGE)
		else $error("accepted bar did not enter range step");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_atr_valid_q |-> res_value_q == '0)
		else $error("invalid result carries nonzero value");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bar_cnt_q <= CNT_W'(PERIOD_MAX + 1))
		else $error("bar count above saturation");

endmodule

// ----- tb/sv/tb_average_true_range.sv -----
// Self-checking testbench for the average true range block: bar requests in, ATR results out.
`timescale 1ns / 1ps

class atr_scoreboard;
	typedef struct packed {
		logic [31:0] value;
		logic        valid;
	} atr_result_t;

	atr_pkg::period_reg_t period_reg;
	int unsigned          bars_seen;
	logic [63:0]          prev_close;
	logic [63:0]          range_total;
	logic [63:0]          smoothed_atr;
	atr_result_t          atr_expected_q[$];
	int                   mismatches;
	int                   results_checked;
	int                   valid_results;

	function new();
		period_reg      = atr_pkg::PERIOD_RESET;
		bars_seen       = 0;
		prev_close      = '0;
		range_total     = '0;
		smoothed_atr    = '0;
		mismatches      = 0;
		results_checked = 0;
		valid_results   = 0;
	endfunction

	function void set_period(atr_pkg::period_reg_t v);
		period_reg = v;
	endfunction

	function int pending();
		return atr_expected_q.size();
	endfunction

	// Predict the result of one accepted bar and queue it.
	function void note_bar(logic [31:0] hi, logic [31:0] lo, logic [31:0] cl);
		int unsigned n;
		logic [63:0] top;
		logic [63:0] bottom;
		logic [63:0] true_range;
		atr_result_t r;
		n = (period_reg == 0) ? 1 : (period_reg > 64) ? 64 : period_reg;
		r = '0;
		if (bars_seen == 0) begin
			prev_close = {32'd0, cl};
			bars_seen  = 1;
		end else begin
			top        = ({32'd0, hi} > prev_close) ? {32'd0, hi} : prev_close;
			bottom     = ({32'd0, lo} < prev_close) ? {32'd0, lo} : prev_close;
			true_range = top - bottom;
			prev_close = {32'd0, cl};
			if (bars_seen < n) begin
				range_total += true_range;
				bars_seen++;
			end else if (bars_seen == n) begin
				range_total += true_range;
				smoothed_atr = range_total / n;
				bars_seen    = n + 1;
				r.valid      = 1'b1;
			end else begin
				// Wilder smoothing; also taken when a smaller period was written
				smoothed_atr = (smoothed_atr * (n - 1) + true_range) / n;
				bars_seen    = n + 1;
				r.valid      = 1'b1;
			end
		end
		if (r.valid)
			r.value = smoothed_atr[31:0];
		atr_expected_q.push_back(r);
	endfunction

	function void check_result(logic [31:0] value, logic valid);
		atr_result_t want;
		results_checked++;
		if (valid)
			valid_results++;
		if (atr_expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ATR result %0d arrived with no bar pending: value=%h valid=%b",
					results_checked, value, valid);
		end else begin
			want = atr_expected_q.pop_front();
			if (want.value !== value || want.valid !== valid) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ATR mismatch at result %0d: expected value=%h valid=%b, got value=%h valid=%b",
						results_checked, want.value, want.valid, value, valid);
			end
		end
	endfunction
endclass

module tb_average_true_range;
	import atr_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int SETTLE_CYCLES = 60;
	localparam int IDLE_LIMIT    = 5000;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_BARS    = 64;
	localparam int NUM_PHASES    = 11;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	period_reg_t cfg_wdata;

	bar_if bar();
	atr_if atr();

	average_true_range u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bar       (bar),
		.atr       (atr),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	atr_scoreboard sb = new();

	always #(CLK_PERIOD / 2) clk = ~clk;

	// result side: random stall modes plus an on-demand long hold-off
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int pattern_cnt = 0;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			atr.ready <= 1'b0;
			hold_left--;
		end else if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = LONG_HOLD;
			atr.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: begin
					atr.ready <= 1'b1;
				end
				1: begin
					atr.ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					atr.ready <= ((pattern_cnt % 7) < 3);
					pattern_cnt++;
				end
			endcase
		end
	end

	// monitors and watchdog
	int bars_in = 0;
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n && bar.valid && bar.ready) begin
			sb.note_bar(bar.bar_high, bar.bar_low, bar.bar_close);
			bars_in++;
		end
		if (arst_n && atr.valid && atr.ready)
			sb.check_result(atr.atr_value, atr.atr_valid);
		if ((bar.valid && bar.ready) || (atr.valid && atr.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
			$display("FAIL average_true_range");
			$finish;
		end
	end

	// bar request side
	logic bar_on = 1'b0;
	int   burst_left = 0;
	int   period_writes = 0;
	logic [31:0] mid_price;

	task automatic drop_bar();
		if (bar_on) begin
			bar.valid <= 1'b0;
			bar_on = 1'b0;
		end
	endtask

	task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo, input logic [31:0] cl);
		int gap;
		bar.valid     <= 1'b1;
		bar.bar_high  <= hi;
		bar.bar_low   <= lo;
		bar.bar_close <= cl;
		bar_on = 1'b1;
		@(posedge clk);
		while (!bar.ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = $urandom_range(0, 25);
			if (gap > 0) begin
				drop_bar();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait for every pending result, then let a bar still in flight finish
	task automatic drain();
		drop_bar();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_period(input period_reg_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_period(v);
		period_writes++;
		@(posedge clk);
	endtask

	task automatic random_bar();
		int kind;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [31:0] cl;
		logic [31:0] step;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			hi = $urandom;
			lo = $urandom;
			cl = $urandom;
		end else begin
			step = $urandom_range(0, 8192);
			if ($urandom_range(0, 1) && mid_price < 32'hFFF0_0000)
				mid_price = mid_price + step;
			else if (mid_price > 32'h0010_0000)
				mid_price = mid_price - step;
			hi = mid_price + $urandom_range(0, 65535);
			lo = mid_price - $urandom_range(0, 65535);
			cl = lo + $urandom_range(0, hi - lo);
			// low above high
			if (kind < 12) begin
				step = hi;
				hi   = lo;
				lo   = step;
			end
		end
		send_bar(hi, lo, cl);
	endtask

	initial begin
		period_reg_t phase_period[NUM_PHASES];
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		bar.valid     <= 1'b0;
		bar.bar_high  <= '0;
		bar.bar_low   <= '0;
		bar.bar_close <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset period: first bar only stores a max close, then extreme ranges
		send_bar(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_bar(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
		send_bar(32'h0002_0000, 32'h0003_0000, 32'hFFFF_FFFF);
		send_bar(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
		for (int i = 5; i < 16; i++)
			send_bar((i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555,
				(i % 2) ? 32'h1555_5555 : 32'h2AAA_AAAA, 32'h4000_0000 + i);
		drain();

		// shrink below the bar count: smoothing resumes at once
		write_period(period_reg_t'(1));
		send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		send_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		drain();
		write_period(period_reg_t'(0));
		send_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF);
		send_bar(32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		drain();

		phase_period[0]  = period_reg_t'(127);
		phase_period[1]  = period_reg_t'(64);
		phase_period[2]  = period_reg_t'(65);
		phase_period[3]  = period_reg_t'(2);
		phase_period[4]  = period_reg_t'(3);
		phase_period[5]  = period_reg_t'(0);
		phase_period[6]  = period_reg_t'(1);
		phase_period[7]  = PERIOD_RESET;
		phase_period[8]  = period_reg_t'($urandom_range(1, 64));
		phase_period[9]  = period_reg_t'($urandom_range(0, 127));
		phase_period[10] = period_reg_t'($urandom_range(4, 20));

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_period(phase_period[p]);
			mid_price = $urandom_range(32'h0010_0000, 32'hFFF0_0000);
			// result side holds off while bars keep coming, so the input backs up
			if (p == 1)
				hold_req <= hold_req + 1;
			for (int i = 0; i < PHASE_BARS; i++) begin
				if (p == 3 && i == PHASE_BARS / 2)
					drain();
				random_bar();
			end
			drain();
		end

		$display("Covered %0d bars and %0d results (%0d with a valid ATR) across %0d period writes,",
			bars_in, sb.results_checked, sb.valid_results, period_writes);
		$display("including period 0 and 127, mid-stream period changes and a long output stall.");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS average_true_range");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
			$display("FAIL average_true_range");
		end
		$finish;
	end
endmodule
